// ===== rtl/core/rred_pkg.sv =====
package rred_pkg;

  localparam int unsigned NUM_W = 32;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_BULK  = 2'd1,
    KIND_ARRAY = 2'd2
  } hdr_kind_t;

  typedef struct packed {
    logic reply_end;
    logic in_payload;
  } rred_flags_t;

endpackage

// ===== rtl/core/rred_in_reg.sv =====
module rred_in_reg
  import rred_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       v_r, v_nxt;
  logic [7:0] byte_r;
  logic       in_fire;

  assign in_tready = !v_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    v_nxt = v_r;
    if (in_fire) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_tdata;
    end
  end

  assign s1_valid = v_r;
  assign s1_byte  = byte_r;

endmodule

// ===== rtl/core/rred_frame.sv =====
module rred_frame
  import rred_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = 20,
  parameter int unsigned PENDING_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [7:0]              byte_i,
  output rred_flags_t             flags,
  output logic [PENDING_BITS-1:0] lines
);

  localparam logic [PAYLOAD_BITS-1:0] PAY_MAX  = '1;
  localparam logic [PENDING_BITS-1:0] PEND_MAX = '1;
  localparam logic [PENDING_BITS-1:0] PEND_ONE = PENDING_BITS'(1);

  logic                    exp_r, exp_nxt;
  hdr_kind_t               kind_r, kind_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic                    neg_r, neg_nxt;
  logic                    open_r, open_nxt;
  logic                    pmode_r, pmode_nxt;
  logic [PAYLOAD_BITS-1:0] pcnt_r, pcnt_nxt;
  logic [PAYLOAD_BITS-1:0] plen_r, plen_nxt;
  logic [PENDING_BITS-1:0] pend_r, pend_nxt;

  // pending-line adder shared by bulk and array headers
  function automatic logic [PENDING_BITS-1:0] pend_add(
    input logic [PENDING_BITS-1:0] p,
    input logic [NUM_W-1:0]        v
  );
    logic [NUM_W:0] s;
    s = (NUM_W+1)'(p) + (NUM_W+1)'(v);
    if ((s >> PENDING_BITS) != '0) begin
      return PEND_MAX;
    end
    return s[PENDING_BITS-1:0];
  endfunction

  function automatic logic [PENDING_BITS-1:0] pend_dec(
    input logic [PENDING_BITS-1:0] p
  );
    if (p != '0) begin
      return p - PEND_ONE;
    end
    return p;
  endfunction

  logic [NUM_W+3:0] num10;
  logic             is_digit;
  logic             pay_done;

  always_comb begin
    num10    = ((NUM_W+4)'(num_r) << 3) + ((NUM_W+4)'(num_r) << 1)
               + (NUM_W+4)'(byte_i[3:0]);
    is_digit = byte_i inside {[CH_ZERO:CH_NINE]};
    pay_done = pcnt_r >= plen_r;

    exp_nxt   = exp_r;
    kind_nxt  = kind_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    open_nxt  = open_r;
    pmode_nxt = pmode_r;
    pcnt_nxt  = pcnt_r;
    plen_nxt  = plen_r;
    pend_nxt  = pend_r;
    flags     = '0;
    lines     = '0;

    if (exp_r) begin
      exp_nxt   = 1'b0;
      pmode_nxt = 1'b0;
      num_nxt   = '0;
      neg_nxt   = 1'b0;
      if (byte_i == CH_DOLLAR) begin
        kind_nxt = KIND_BULK;
        open_nxt = 1'b1;
        pend_nxt = pend_add(pend_r, NUM_W'(1));
      end else if (byte_i == CH_STAR) begin
        kind_nxt = KIND_ARRAY;
        open_nxt = 1'b1;
      end else begin
        kind_nxt = KIND_OTHER;
        open_nxt = 1'b0;
      end
    end else if (pmode_r) begin
      flags.in_payload = !pay_done;
      // an early line feed is payload data
      if (byte_i == CH_LF && pay_done) begin
        pmode_nxt = 1'b0;
        exp_nxt   = 1'b1;
        pend_nxt  = pend_dec(pend_r);
      end else if (pcnt_r != PAY_MAX) begin
        pcnt_nxt = pcnt_r + PAYLOAD_BITS'(1);
      end
    end else if (byte_i == CH_LF) begin
      open_nxt = 1'b0;
      exp_nxt  = 1'b1;
      if (kind_r == KIND_BULK) begin
        // null bulk closes its line with no payload
        if (neg_r && num_r == NUM_W'(1)) begin
          pend_nxt = pend_dec(pend_r);
        end else begin
          pmode_nxt = 1'b1;
          pcnt_nxt  = '0;
          if (neg_r) begin
            plen_nxt = '0;
          end else if ((num_r >> PAYLOAD_BITS) != '0) begin
            plen_nxt = PAY_MAX;
          end else begin
            plen_nxt = num_r[PAYLOAD_BITS-1:0];
          end
          exp_nxt = 1'b0;
        end
      end else if (kind_r == KIND_ARRAY && !neg_r) begin
        pend_nxt = pend_add(pend_r, num_r);
      end
      kind_nxt = KIND_OTHER;
      pend_nxt = pend_dec(pend_nxt);
    end else if (open_r) begin
      if (is_digit) begin
        num_nxt = (num10[NUM_W+3:NUM_W] != '0) ? '1 : num10[NUM_W-1:0];
      end else if (byte_i == CH_MINUS && num_r == '0 && !neg_r) begin
        neg_nxt = 1'b1;
      end else begin
        open_nxt = 1'b0;
      end
    end

    lines = pend_nxt;
    // rearm at the reply's last byte
    if (pend_nxt == '0) begin
      flags.reply_end = 1'b1;
      exp_nxt   = 1'b1;
      kind_nxt  = KIND_OTHER;
      num_nxt   = '0;
      neg_nxt   = 1'b0;
      open_nxt  = 1'b0;
      pmode_nxt = 1'b0;
      pcnt_nxt  = '0;
      plen_nxt  = '0;
      pend_nxt  = PEND_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= 1'b1;
      kind_r  <= KIND_OTHER;
      num_r   <= '0;
      neg_r   <= 1'b0;
      open_r  <= 1'b0;
      pmode_r <= 1'b0;
      pcnt_r  <= '0;
      plen_r  <= '0;
      pend_r  <= PEND_ONE;
    end else if (fire) begin
      exp_r   <= exp_nxt;
      kind_r  <= kind_nxt;
      num_r   <= num_nxt;
      neg_r   <= neg_nxt;
      open_r  <= open_nxt;
      pmode_r <= pmode_nxt;
      pcnt_r  <= pcnt_nxt;
      plen_r  <= plen_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_hdr_pay_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(exp_r && pmode_r))
    else $error("header and payload expected together");

  a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && flags.reply_end) |=> (exp_r && !pmode_r && pend_r == PEND_ONE))
    else $error("no rearm after reply end");

  a_pay_mode: assert property (@(posedge clk) disable iff (!rst_n)
    flags.in_payload |-> (pmode_r && pcnt_r < plen_r))
    else $error("payload flag outside payload");

  a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != '0)
    else $error("pending count held at zero");

endmodule

// ===== rtl/core/resp_reply_end_detector.sv =====
// Pipeline: an accepted input byte is held in the input register, then its result item is
// written into the output register, where it is valid; a stall on the output holds both.
// Throughput: one item per cycle while the output is not stalled; the line-count update
// for each byte is combinational between the input register and the output register.
// Reset (rst_n low, synchronous): both pipeline registers are emptied and the
// framing state returns to header expected with one line pending.
module resp_reply_end_detector
  import rred_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = 20,
  parameter int unsigned PENDING_BITS = 24,
  localparam int unsigned OUT_W = ((8 + PENDING_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // [7:0] byte_out, then lines_pending, zero pad
  output logic             out_tlast,  // reply_end
  output logic             out_tuser   // in_payload
);

  logic                    adv;
  logic                    fire;
  logic                    s1_valid;
  logic [7:0]              s1_byte;
  rred_flags_t             flags;
  logic [PENDING_BITS-1:0] lines;

  logic                    out_v_r, out_v_nxt;
  logic [7:0]              byte_r;
  logic [PENDING_BITS-1:0] lines_r;
  rred_flags_t             flags_r;

  // advance when the output register is free or being drained
  assign adv  = !out_v_r || out_tready;
  assign fire = s1_valid && adv;

  rred_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  rred_frame #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_i (s1_byte),
    .flags  (flags),
    .lines  (lines)
  );

  always_comb begin
    out_v_nxt = adv ? s1_valid : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r  <= s1_byte;
      lines_r <= lines;
      flags_r <= flags;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({lines_r, byte_r});
  assign out_tlast  = flags_r.reply_end;
  assign out_tuser  = flags_r.in_payload;

endmodule

// ===== bench/resp_reply_checker.sv =====
module resp_reply_checker
  import rred_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = 20,
  parameter int unsigned PENDING_BITS = 24,
  parameter int unsigned OUT_W        = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // [7:0] byte_out, then lines_pending, zero pad
  input  logic             out_tlast,  // reply_end
  input  logic             out_tuser,  // in_payload
  output int               fail_count,
  output int               outstanding
);

  localparam logic [PAYLOAD_BITS-1:0] BODY_MAX  = '1;
  localparam logic [PENDING_BITS-1:0] LINES_MAX = '1;

  typedef struct packed {
    logic [7:0]              data;
    logic                    last;
    logic                    payload;
    logic [PENDING_BITS-1:0] lines;
  } reply_byte_t;

  reply_byte_t reply_q[$];
  reply_byte_t exp_r;
  int          results_seen;

  // framing state
  logic                    want_header;
  hdr_kind_t               kind;
  logic [NUM_W-1:0]        num_val;
  logic                    num_neg;
  logic                    num_live;
  logic                    in_body;
  logic [PAYLOAD_BITS-1:0] body_seen;
  logic [PAYLOAD_BITS-1:0] body_len;
  logic [PENDING_BITS-1:0] lines_left;

  function automatic void clear_state();
    want_header = 1'b1;
    kind        = KIND_OTHER;
    num_val     = '0;
    num_neg     = 1'b0;
    num_live    = 1'b0;
    in_body     = 1'b0;
    body_seen   = '0;
    body_len    = '0;
    lines_left  = PENDING_BITS'(1);
  endfunction

  function automatic void lines_add(input logic [NUM_W-1:0] v);
    logic [63:0] sum;
    sum = 64'(lines_left) + 64'(v);
    lines_left = (sum > 64'(LINES_MAX)) ? LINES_MAX : sum[PENDING_BITS-1:0];
  endfunction

  function automatic void lines_sub();
    if (lines_left != 0) lines_left = lines_left - 1'b1;
  endfunction

  function automatic reply_byte_t frame_byte(input logic [7:0] b);
    reply_byte_t r;
    logic [63:0] acc;
    r.data    = b;
    r.last    = 1'b0;
    r.payload = 1'b0;
    if (want_header) begin
      want_header = 1'b0;
      in_body     = 1'b0;
      num_val     = '0;
      num_neg     = 1'b0;
      if (b == CH_DOLLAR) begin
        kind     = KIND_BULK;
        num_live = 1'b1;
        lines_add(1);
      end else if (b == CH_STAR) begin
        kind     = KIND_ARRAY;
        num_live = 1'b1;
      end else begin
        kind     = KIND_OTHER;
        num_live = 1'b0;
      end
    end else if (in_body) begin
      r.payload = (body_seen < body_len);
      // a line feed before the stated length is plain payload data
      if (b == CH_LF && body_seen >= body_len) begin
        in_body     = 1'b0;
        want_header = 1'b1;
        lines_sub();
      end else if (body_seen != BODY_MAX) begin
        body_seen = body_seen + 1'b1;
      end
    end else if (b == CH_LF) begin
      num_live    = 1'b0;
      want_header = 1'b1;
      if (kind == KIND_BULK) begin
        if (num_neg && num_val == 1) begin
          lines_sub();
        end else begin
          in_body     = 1'b1;
          body_seen   = '0;
          body_len    = num_neg ? '0 :
                        ((num_val > BODY_MAX) ? BODY_MAX : num_val[PAYLOAD_BITS-1:0]);
          want_header = 1'b0;
        end
      end else if (kind == KIND_ARRAY && !num_neg) begin
        lines_add(num_val);
      end
      kind = KIND_OTHER;
      lines_sub();
    end else if (num_live) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        acc     = 64'(num_val) * 64'd10 + 64'(b - CH_ZERO);
        num_val = (acc > 64'hFFFF_FFFF) ? '1 : acc[NUM_W-1:0];
      end else if (b == CH_MINUS && num_val == 0 && !num_neg) begin
        num_neg = 1'b1;
      end else begin
        num_live = 1'b0;
      end
    end
    r.lines = lines_left;
    if (lines_left == 0) begin
      r.last = 1'b1;
      clear_state();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (fail_count < 100)
      $display("checker: result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      reply_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", out_tdata, 0);
        end else begin
          exp_r = reply_q.pop_front();
          if (out_tdata[7:0] !== exp_r.data)
            report_mismatch("byte_out", out_tdata[7:0], exp_r.data);
          if (out_tdata[8 +: PENDING_BITS] !== exp_r.lines)
            report_mismatch("lines_pending", out_tdata[8 +: PENDING_BITS], exp_r.lines);
          if ((out_tdata >> (8 + PENDING_BITS)) !== 0)
            report_mismatch("tdata padding", out_tdata >> (8 + PENDING_BITS), 0);
          if (out_tlast !== exp_r.last)
            report_mismatch("reply_end", out_tlast, exp_r.last);
          if (out_tuser !== exp_r.payload)
            report_mismatch("in_payload", out_tuser, exp_r.payload);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) reply_q.insert(reply_q.size(), frame_byte(in_tdata));
    end
    outstanding <= reply_q.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import rred_pkg::*;

  localparam int unsigned PAYLOAD_BITS = 20;
  localparam int unsigned PENDING_BITS = 24;
  localparam int unsigned OUT_W        = ((8 + PENDING_BITS + 7) / 8) * 8;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_BYTES = 1900;
  localparam logic [7:0]  CH_CR        = 8'h0D;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  int         fail_count;
  int         outstanding;
  int         idle_cycles = 0;
  bit         no_idle     = 1'b0;
  logic [7:0] stream[$];

  resp_reply_end_detector #(
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .PENDING_BITS(PENDING_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  resp_reply_checker #(
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .PENDING_BITS(PENDING_BITS),
    .OUT_W       (OUT_W)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic append_byte(input logic [7:0] b);
    stream.insert(stream.size(), b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] skip_a, input logic [7:0] skip_b);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == skip_a || b == skip_b) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // decimal count, sometimes with a leading zero or a trailing minus that ends it
  task automatic put_count(input int n);
    if ($urandom_range(0, 7) == 0) append_byte(CH_ZERO);
    put_text($sformatf("%0d", n));
    if (n != 0 && $urandom_range(0, 9) == 0) append_byte(CH_MINUS);
  endtask

  task automatic gen_reply(input int depth);
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 3 || depth > 2) begin
      append_byte(pick_byte(CH_DOLLAR, CH_STAR));
      n = $urandom_range(0, 4);
      repeat (n) append_byte(pick_byte(CH_LF, CH_LF));
      append_byte(CH_CR);
      append_byte(CH_LF);
    end else if (pick < 7) begin
      append_byte(CH_DOLLAR);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        put_text("-1\r\n");
      end else if (pick == 1) begin
        // negative length other than -1: empty payload
        n = $urandom_range(0, 3);
        if (n == 1) n = 9;
        append_byte(CH_MINUS);
        put_text($sformatf("%0d", n));
        put_text("\r\n\r\n");
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        put_count(n);
        put_text("\r\n");
        repeat (n) append_byte(8'($urandom_range(0, 255)));
        put_text("\r\n");
      end
    end else begin
      append_byte(CH_STAR);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        put_text("-1\r\n");
      end else if (pick == 1) begin
        put_text("-2\r\n");
      end else begin
        n = $urandom_range(0, 3);
        put_count(n);
        put_text("\r\n");
        repeat (n) gen_reply(depth + 1);
      end
    end
  endtask

  // receiver: draw a stall before each result
  initial begin : sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int gap;
    int pick;
    int n;
    int mark;
    int cut;
    int target;
    int pause_a;
    int pause_b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // plain lines opened by a zero byte and by a line feed
    append_byte(8'h00);
    append_byte(CH_LF);
    append_byte(CH_LF);
    append_byte(CH_LF);
    // null bulk, null array, array holding a bulk with an early line feed
    put_text("$-1\n*-1\n*1\n$2\n\n");
    append_byte(8'hFF);
    append_byte(CH_LF);
    // negative bulk length: empty payload closed by the next line feed
    put_text("$-3\n\n");
    pause_a = stream.size();

    target = stream.size() + RANDOM_BYTES;
    while (stream.size() < target) begin
      pick = $urandom_range(0, 19);
      if (stream.size() + 300 < target && pick == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) append_byte(pick_byte(CH_DOLLAR, CH_STAR));
      end else if (stream.size() + 300 < target && pick < 3) begin
        // truncate a reply somewhere inside
        mark = stream.size();
        gen_reply(0);
        if (stream.size() > mark + 1) begin
          cut = $urandom_range(mark + 1, stream.size() - 1);
          while (stream.size() > cut) void'(stream.pop_back());
        end
      end else begin
        gen_reply(0);
      end
    end
    pause_b = pause_a + (stream.size() - pause_a) / 2;

    // sign after a zero, doubled sign, minus after digits, then saturation
    put_text("*0-3\r\n$--2\r\n\r\n*1-2\r\n:1\r\n");
    put_text("*99999999999\r\n*5\r\n$99999999999\r\nab\n");

    for (int i = 0; i < stream.size(); i++) begin
      no_idle <= ((i / 128) % 4) == 3;
      if (i == pause_a || i == pause_b) begin
        // hold off until every result is back
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stream[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
